@@ sv/ppts_pkg.sv @@
// Package for the preemptive priority task scheduler: types, codes, id rank table.
// No dependencies.
package ppts_pkg;
    typedef enum logic [1:0] {
        K_ADMIT = 2'd0,
        K_START = 2'd1,
        K_INSTR = 2'd2,
        K_TICK  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STOP_NONE    = 2'd0,
        STOP_DONE    = 2'd1,
        STOP_PREEMPT = 2'd2,
        STOP_QUANTUM = 2'd3
    } t_stop;

    typedef enum logic [2:0] {
        REG_SILVER_Q   = 3'd0,
        REG_GOLD_Q     = 3'd1,
        REG_SWITCH_DLY = 3'd2,
        REG_SILVER_PRM = 3'd3,
        REG_GOLD_PRM   = 3'd4
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_WRITE,
        S_RESCHED,
        S_DONE
    } t_state;

    localparam logic [1:0]  CLS_SILVER   = 2'd0;
    localparam logic [1:0]  CLS_GOLD     = 2'd1;
    localparam logic [1:0]  CLS_PLATINUM = 2'd2;
    localparam logic [19:0] TIME_MAX     = 20'hFFFFF;
    localparam logic [10:0] SLICE_MAX    = 11'h7FF;

    // Entry record, one memory word.
    typedef struct packed {
        logic [6:0]  id;
        logic [7:0]  prio;
        logic [1:0]  cls;
        logic [19:0] ready;
        logic [2:0]  quanta;
        logic        done;
    } t_entry;

    function automatic logic text_less(input logic [6:0] a, input logic [6:0] b);
        logic [3:0] ta [3];
        logic [3:0] tb [3];
        int la;
        int lb;
        int i;
        logic res;
        logic fin;
        la = (a >= 7'd100) ? 3 : (a >= 7'd10) ? 2 : 1;
        lb = (b >= 7'd100) ? 3 : (b >= 7'd10) ? 2 : 1;
        ta[0] = 4'((la == 3) ? 1 : (la == 2) ? int'(a) / 10 : int'(a));
        ta[1] = 4'((la == 3) ? (int'(a) / 10) % 10 : int'(a) % 10);
        ta[2] = 4'(int'(a) % 10);
        tb[0] = 4'((lb == 3) ? 1 : (lb == 2) ? int'(b) / 10 : int'(b));
        tb[1] = 4'((lb == 3) ? (int'(b) / 10) % 10 : int'(b) % 10);
        tb[2] = 4'(int'(b) % 10);
        res = (la < lb);
        fin = 1'b0;
        for (i = 0; i < 3; i++) begin
            if (!fin && i < la && i < lb && ta[i] != tb[i]) begin
                res = ta[i] < tb[i];
                fin = 1'b1;
            end
        end
        return res;
    endfunction

    // rank of every id 0..127, 7 bits each; evaluated at elaboration only
    function automatic logic [895:0] rank_table();
        logic [895:0] t;
        logic [6:0]   r;
        t = '0;
        for (int a = 0; a < 128; a++) begin
            r = 7'd0;
            for (int v = 0; v < 128; v++) begin
                if (text_less(7'(v), 7'(a))) r = r + 7'd1;
            end
            t[a*7 +: 7] = r;
        end
        return t;
    endfunction

    localparam logic [895:0] ID_RANK = rank_table();

    // Rank of an id in decimal-text order (0..127); smaller sorts first.
    function automatic logic [6:0] id_rank(input logic [6:0] id);
        return ID_RANK[10'(id) * 10'd7 +: 7];
    endfunction
endpackage

@@ sv/ppts_table.sv @@
// Task table memory: one write port, one registered read port.
// Depends on ppts_pkg.
module ppts_table #(
    parameter int ENTRIES = 16,
    parameter int AW = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  ppts_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output ppts_pkg::t_entry o_rdata
);
    import ppts_pkg::*;
    t_entry mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        o_rdata <= mem[i_raddr];
    end
endmodule

@@ sv/preemptive_priority_task_scheduler_core.sv @@
// Preemptive priority task scheduler: task table in one memory with a scan sequencer.
// Admit and ignored events go straight to the result; tick and start scan the table once, and an
// instruction scans once and, when the running task stops, writes it back and scans again.
// Throughput: one event at a time; busy is high until the result strobe.
// Reset (synchronous, active low) empties the table, zeroes time and loads default registers.
// Results come as a one-cycle strobe on o_done; the receiver cannot stall.
module preemptive_priority_task_scheduler_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_slot,
    input  logic [6:0]  i_task_id,
    input  logic [7:0]  i_priority_req,
    input  logic [1:0]  i_task_class,
    input  logic [19:0] i_arrival_time,
    input  logic [7:0]  i_step_duration,
    input  logic        i_ends_task,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    output logic        o_done,
    output logic        o_run_valid,
    output logic [3:0]  o_run_slot,
    output logic [19:0] o_now_time,
    output logic [1:0]  o_stop_reason,
    output logic        o_promoted,
    output logic        o_switched
);
    import ppts_pkg::*;
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    t_state r_state, n_state;
    logic [9:0]  r_silver_q, r_gold_q;
    logic [7:0]  r_sw_dly;
    logic [2:0]  r_silver_prm, r_gold_prm;
    logic [TABLE_ENTRIES-1:0] r_vld;
    logic [19:0] r_time;
    logic [10:0] r_slice;
    logic        r_run_on, r_prev_on;
    logic [AW-1:0] r_running, r_prev;
    // latched request
    t_kind       r_kind;
    logic        r_ends;
    // scan
    logic [AW:0]   r_idx;
    logic [AW-1:0] r_cmp;
    logic          r_found, r_yield, r_force;
    logic [AW-1:0] r_best;
    t_entry        r_bent;
    logic [6:0]    r_brank;
    t_entry        r_rent;
    logic [1:0]    r_stop;
    logic          r_prom, r_sw;
    logic          r_pass2;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata, cur;

    ppts_table #(.ENTRIES(TABLE_ENTRIES), .AW(AW)) u_table (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign cur = r_vld[r_cmp] ? rdata : '0;

    logic       elig, above, yld;
    logic [6:0] crank;
    assign crank = id_rank(cur.id);
    assign elig = (cur.id != 7'd0) && !cur.done && (cur.ready <= r_time);
    // best strictly above current
    always_comb begin
        logic pb, pc;
        pb = (r_bent.cls == CLS_PLATINUM);
        pc = (cur.cls == CLS_PLATINUM);
        if (pb != pc) above = pb;
        else if (r_bent.prio != cur.prio) above = r_bent.prio > cur.prio;
        else if (r_bent.ready != cur.ready) above = r_bent.ready < cur.ready;
        else above = r_brank < crank;
    end
    assign yld = elig && (r_cmp != r_running) &&
                 ((cur.cls == CLS_PLATINUM) || (cur.prio > r_rent.prio));

    // stop decision once the first scan has finished
    logic [1:0] stop_c;
    always_comb begin
        if (r_ends) stop_c = STOP_DONE;
        else if (r_rent.cls != CLS_PLATINUM && r_yield) stop_c = STOP_PREEMPT;
        else if (r_rent.cls != CLS_PLATINUM && r_slice >= {1'b0,
                 (r_rent.cls == CLS_SILVER) ? r_silver_q : r_gold_q})
            stop_c = STOP_QUANTUM;
        else stop_c = STOP_NONE;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) begin
                case (t_kind'(i_kind))
                    K_ADMIT: n_state = S_DONE;
                    K_START: n_state = S_SCAN;
                    K_INSTR: n_state = r_run_on ? S_SCAN : S_DONE;
                    K_TICK:  n_state = r_run_on ? S_DONE : S_SCAN;
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN:      if (r_idx == (AW+1)'(TABLE_ENTRIES)) n_state = S_SCAN_LAST;
            S_SCAN_LAST: n_state = (r_kind == K_INSTR && !r_pass2) ? S_WRITE : S_RESCHED;
            S_WRITE:     n_state = (r_stop != STOP_NONE) ? S_SCAN : S_DONE;
            S_RESCHED:   n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        we = 1'b0;
        waddr = r_running;
        wdata = r_rent;
        raddr = r_idx[AW-1:0];
        if (r_state == S_IDLE && start && t_kind'(i_kind) == K_ADMIT
            && 32'(i_slot) < TABLE_ENTRIES) begin
            we = 1'b1;
            waddr = AW'(i_slot);
            wdata.id = i_task_id;
            wdata.prio = i_priority_req;
            wdata.cls = (i_task_class > CLS_PLATINUM) ? CLS_PLATINUM : i_task_class;
            wdata.ready = i_arrival_time;
            wdata.quanta = 3'd0;
            wdata.done = 1'b0;
        end else if (r_state == S_WRITE && r_stop != STOP_NONE) begin
            we = 1'b1;
        end
        if (r_state == S_IDLE) raddr = r_running;
    end

    logic [20:0] t_add;
    logic [11:0] s_add;
    logic [2:0]  q_inc;
    logic [20:0] t_sw;
    assign t_add = {1'b0, r_time} + {13'd0, i_step_duration};
    assign s_add = {1'b0, r_slice} + {4'd0, i_step_duration};
    assign q_inc = r_rent.quanta + 3'd1;
    assign t_sw  = {1'b0, r_time} + {13'd0, r_sw_dly};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_silver_q <= 10'd80; r_gold_q <= 10'd120; r_sw_dly <= 8'd10;
            r_silver_prm <= 3'd3; r_gold_prm <= 3'd5;
            r_vld <= '0; r_time <= '0; r_slice <= '0;
            r_run_on <= 1'b0; r_prev_on <= 1'b0; r_running <= '0; r_prev <= '0;
            o_done <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_SILVER_Q:   r_silver_q <= i_cfg_data;
                    REG_GOLD_Q:     r_gold_q <= i_cfg_data;
                    REG_SWITCH_DLY: r_sw_dly <= i_cfg_data[7:0];
                    REG_SILVER_PRM: r_silver_prm <= i_cfg_data[2:0];
                    REG_GOLD_PRM:   r_gold_prm <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (we) r_vld[waddr] <= 1'b1;
            case (r_state)
                S_IDLE: if (start) begin
                    r_kind <= t_kind'(i_kind);
                    r_ends <= i_ends_task;
                    r_idx <= '0;
                    r_found <= 1'b0; r_yield <= 1'b0; r_pass2 <= 1'b0;
                    r_stop <= STOP_NONE; r_prom <= 1'b0; r_sw <= 1'b0;
                    r_force <= (t_kind'(i_kind) == K_START);
                    if (t_kind'(i_kind) == K_TICK && !r_run_on)
                        r_time <= (r_time == TIME_MAX) ? TIME_MAX : r_time + 20'd1;
                    if (t_kind'(i_kind) == K_INSTR && r_run_on) begin
                        r_time <= (t_add > {1'b0, TIME_MAX}) ? TIME_MAX : t_add[19:0];
                        r_slice <= (s_add > {1'b0, SLICE_MAX}) ? SLICE_MAX : s_add[10:0];
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + (AW+1)'(1);
                    r_cmp <= r_idx[AW-1:0];
                    if (r_idx == '0 && !r_pass2) r_rent <= r_vld[r_running] ? rdata : '0;
                    if (r_idx != '0) begin
                        if (elig && (!r_found || !above)) begin
                            r_best <= r_cmp; r_bent <= cur; r_brank <= crank;
                        end
                        if (elig) r_found <= 1'b1;
                        if (yld) r_yield <= 1'b1;
                    end
                end
                S_SCAN_LAST: if (r_kind == K_INSTR && !r_pass2) begin
                    // updated running entry for the write cycle
                    r_stop <= stop_c;
                    if (stop_c == STOP_DONE) begin
                        r_rent.quanta <= q_inc; r_rent.done <= 1'b1;
                    end else if (stop_c != STOP_NONE) begin
                        r_rent.ready <= r_time;
                        if ((r_rent.cls == CLS_SILVER && q_inc == r_silver_prm) ||
                            (r_rent.cls == CLS_GOLD && q_inc == r_gold_prm)) begin
                            r_rent.cls <= r_rent.cls + 2'd1; r_rent.quanta <= 3'd0;
                            r_prom <= 1'b1;
                        end else begin
                            r_rent.quanta <= q_inc;
                        end
                    end
                end
                S_WRITE: begin
                    r_idx <= '0; r_found <= 1'b0; r_pass2 <= 1'b1;
                end
                S_RESCHED: begin
                    if (r_force || (r_found && (!r_prev_on || r_best != r_prev))) begin
                        r_time <= (t_sw > {1'b0, TIME_MAX}) ? TIME_MAX : t_sw[19:0];
                        r_sw <= 1'b1;
                    end
                    r_run_on <= r_found; r_prev_on <= r_found;
                    r_running <= r_found ? r_best : '0;
                    r_prev <= r_found ? r_best : '0;
                    r_slice <= '0;
                end
                S_DONE: o_done <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_run_valid   = r_run_on;
    assign o_run_slot    = r_run_on ? 4'(r_running) : 4'd0;
    assign o_now_time    = r_time;
    assign o_stop_reason = r_stop;
    assign o_promoted    = r_prom;
    assign o_switched    = r_sw;

    a_busy_no_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cfg_ready) else $error("cfg ready while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE)) else $error("strobe outside idle");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run_on |-> (r_running == '0)) else $error("running slot set while none");
endmodule

@@ tb/tb_preemptive_priority_task_scheduler_core.sv @@
// Self-checking testbench for preemptive_priority_task_scheduler_core.
// Depends on ppts_pkg and the core; an internal scheduler predictor checks every result.
`timescale 1ns / 100ps

module tb_preemptive_priority_task_scheduler_core;
    import ppts_pkg::*;

    localparam int NUM_SLOTS  = 16;
    localparam int CYCLE_CAP  = 600000;

    typedef struct {
        t_kind       kind;
        logic [3:0]  slot;
        logic [6:0]  id;
        logic [7:0]  prio;
        logic [1:0]  cls;
        logic [19:0] arrival;
        logic [7:0]  dur;
        logic        ends;
    } t_event_req;

    typedef struct {
        logic        run_valid;
        logic [3:0]  run_slot;
        logic [19:0] now_time;
        t_stop       stop;
        logic        promoted;
        logic        switched;
    } t_sched_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_kind = K_ADMIT;
    logic [3:0]  i_slot = '0;
    logic [6:0]  i_task_id = '0;
    logic [7:0]  i_priority_req = '0;
    logic [1:0]  i_task_class = '0;
    logic [19:0] i_arrival_time = '0;
    logic [7:0]  i_step_duration = '0;
    logic        i_ends_task = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = REG_SILVER_Q;
    logic [9:0]  i_cfg_data = '0;
    logic        o_done;
    logic        o_run_valid;
    logic [3:0]  o_run_slot;
    logic [19:0] o_now_time;
    logic [1:0]  o_stop_reason;
    logic        o_promoted;
    logic        o_switched;

    preemptive_priority_task_scheduler_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- scheduler predictor ----------------
    logic [9:0]  q_silver = 10'd80;
    logic [9:0]  q_gold = 10'd120;
    logic [7:0]  sw_delay = 8'd10;
    logic [2:0]  prm_silver = 3'd3;
    logic [2:0]  prm_gold = 3'd5;

    logic [6:0]  tbl_id     [NUM_SLOTS];
    logic [7:0]  tbl_prio   [NUM_SLOTS];
    logic [1:0]  tbl_cls    [NUM_SLOTS];
    logic [19:0] tbl_ready  [NUM_SLOTS];
    logic [2:0]  tbl_quanta [NUM_SLOTS];
    logic        tbl_done   [NUM_SLOTS];
    logic [19:0] sys_time = '0;
    logic [10:0] slice = '0;
    logic        cur_on = 1'b0;
    logic        last_on = 1'b0;
    logic [3:0]  cur_slot = '0;
    logic [3:0]  last_slot = '0;

    initial begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            tbl_id[k] = '0; tbl_prio[k] = '0; tbl_cls[k] = '0;
            tbl_ready[k] = '0; tbl_quanta[k] = '0; tbl_done[k] = 1'b0;
        end
    end

    function automatic logic [19:0] time_add(logic [19:0] a, int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > 20'hFFFFF) ? 20'hFFFFF : s[19:0];
    endfunction

    function automatic bit runnable(int k);
        return tbl_id[k] != 0 && !tbl_done[k] && tbl_ready[k] <= sys_time;
    endfunction

    // ids compare as decimal text
    function automatic bit id_text_before(logic [6:0] a, logic [6:0] b);
        string sa;
        string sb;
        sa = $sformatf("%0d", a);
        sb = $sformatf("%0d", b);
        return sa < sb;
    endfunction

    function automatic bit outranks(int a, int b);
        bit pa;
        bit pb;
        pa = tbl_cls[a] == CLS_PLATINUM;
        pb = tbl_cls[b] == CLS_PLATINUM;
        if (pa != pb) return pa;
        if (tbl_prio[a] != tbl_prio[b]) return tbl_prio[a] > tbl_prio[b];
        if (tbl_ready[a] != tbl_ready[b]) return tbl_ready[a] < tbl_ready[b];
        return id_text_before(tbl_id[a], tbl_id[b]);
    endfunction

    function automatic bit has_rival(int r);
        for (int k = 0; k < NUM_SLOTS; k++)
            if (k != r && runnable(k) && (tbl_cls[k] == CLS_PLATINUM || tbl_prio[k] > tbl_prio[r]))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit dispatch_next(bit force_sw);
        bit found;
        int best;
        bit sw;
        found = 1'b0;
        best = 0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (!runnable(k)) continue;
            // later entry wins a full tie
            if (!found || !outranks(best, k)) best = k;
            found = 1'b1;
        end
        sw = force_sw || (found && (!last_on || best[3:0] != last_slot));
        if (sw) sys_time = time_add(sys_time, sw_delay);
        cur_on = found;
        cur_slot = found ? best[3:0] : 4'd0;
        last_on = found;
        last_slot = cur_slot;
        slice = '0;
        return sw;
    endfunction

    function automatic t_sched_out sched_event(t_event_req e);
        t_sched_out o;
        int r;
        logic [1:0] c;
        int unsigned sl;
        o.stop = STOP_NONE;
        o.promoted = 1'b0;
        o.switched = 1'b0;
        case (e.kind)
            K_ADMIT: begin
                tbl_id[e.slot] = e.id;
                tbl_prio[e.slot] = e.prio;
                tbl_cls[e.slot] = (e.cls > CLS_PLATINUM) ? CLS_PLATINUM : e.cls;
                tbl_ready[e.slot] = e.arrival;
                tbl_quanta[e.slot] = '0;
                tbl_done[e.slot] = 1'b0;
            end
            K_START: o.switched = dispatch_next(1'b1);
            K_INSTR: begin
                if (cur_on) begin
                    r = cur_slot;
                    c = tbl_cls[r];
                    sys_time = time_add(sys_time, e.dur);
                    sl = slice + e.dur;
                    slice = (sl > 2047) ? 11'h7FF : sl[10:0];
                    if (e.ends) o.stop = STOP_DONE;
                    else if (c != CLS_PLATINUM && has_rival(r)) o.stop = STOP_PREEMPT;
                    else if (c != CLS_PLATINUM &&
                             slice >= ((c == CLS_SILVER) ? q_silver : q_gold))
                        o.stop = STOP_QUANTUM;
                    if (o.stop != STOP_NONE) begin
                        tbl_quanta[r] = tbl_quanta[r] + 3'd1;
                        if (o.stop == STOP_DONE) begin
                            tbl_done[r] = 1'b1;
                        end else begin
                            tbl_ready[r] = sys_time;
                            if ((c == CLS_SILVER && tbl_quanta[r] == prm_silver) ||
                                (c == CLS_GOLD && tbl_quanta[r] == prm_gold)) begin
                                tbl_cls[r] = c + 2'd1;
                                tbl_quanta[r] = '0;
                                o.promoted = 1'b1;
                            end
                        end
                        o.switched = dispatch_next(1'b0);
                    end
                end
            end
            default: begin
                if (!cur_on) begin
                    sys_time = time_add(sys_time, 1);
                    o.switched = dispatch_next(1'b0);
                end
            end
        endcase
        o.run_valid = cur_on;
        o.run_slot = cur_on ? cur_slot : 4'd0;
        o.now_time = sys_time;
        return o;
    endfunction

    // ---------------- driver ----------------
    t_event_req pending_reqs[$];
    t_sched_out expected_outs[$];
    t_event_req cur_req;
    int  send_idle_pct = 0;
    int  reqs_sent = 0;
    int  outs_checked = 0;
    int  errors = 0;
    int  stop_seen[4] = '{0, 0, 0, 0};
    int  promos_seen = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_outs.push_back(sched_event(cur_req));
                reqs_sent++;
            end
            if ((!start || !busy) && pending_reqs.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                cur_req = pending_reqs.pop_front();
                i_kind <= cur_req.kind;
                i_slot <= cur_req.slot;
                i_task_id <= cur_req.id;
                i_priority_req <= cur_req.prio;
                i_task_class <= cur_req.cls;
                i_arrival_time <= cur_req.arrival;
                i_step_duration <= cur_req.dur;
                i_ends_task <= cur_req.ends;
                start <= 1'b1;
            end else if (start && !busy) begin
                start <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sched_out exp_o;
        if (i_rst_n && o_done) begin
            if (expected_outs.size() == 0) begin
                $display("%0t ns: unexpected result, actual slot %0d time %0d", $time,
                         o_run_slot, o_now_time);
                errors++;
            end else begin
                exp_o = expected_outs.pop_front();
                check_field("run_valid", exp_o.run_valid, o_run_valid);
                check_field("run_slot", exp_o.run_slot, o_run_slot);
                check_field("now_time", exp_o.now_time, o_now_time);
                check_field("stop_reason", exp_o.stop, o_stop_reason);
                check_field("promoted", exp_o.promoted, o_promoted);
                check_field("switched", exp_o.switched, o_switched);
                outs_checked++;
                stop_seen[exp_o.stop]++;
                if (exp_o.promoted) promos_seen++;
            end
        end
    end

    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_preemptive_priority_task_scheduler_core: done, errors");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    int unsigned est_time = 0;

    task automatic add_req(t_kind k, int slot, int id, int prio, int cls, int arr, int dur,
                           int ends);
        t_event_req e;
        e.kind = k; e.slot = slot[3:0]; e.id = id[6:0]; e.prio = prio[7:0];
        e.cls = cls[1:0]; e.arrival = arr[19:0]; e.dur = dur[7:0]; e.ends = ends[0];
        pending_reqs.push_back(e);
    endtask

    task automatic cfg_write(t_reg idx, int data);
        i_cfg_index <= idx;
        i_cfg_data <= data[9:0];
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_SILVER_Q:   q_silver = data[9:0];
            REG_GOLD_Q:     q_gold = data[9:0];
            REG_SWITCH_DLY: sw_delay = data[7:0];
            REG_SILVER_PRM: prm_silver = data[2:0];
            default:        prm_gold = data[2:0];
        endcase
    endtask

    task automatic configure(int sq, int gq, int dly, int sp, int gp);
        cfg_write(REG_SILVER_Q, sq);
        cfg_write(REG_GOLD_Q, gq);
        cfg_write(REG_SWITCH_DLY, dly);
        cfg_write(REG_SILVER_PRM, sp);
        cfg_write(REG_GOLD_PRM, gp);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || start || expected_outs.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic add_random(int n);
        int sel;
        int dur;
        int arr;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 25) begin
                arr = ($urandom_range(19) == 0) ? $urandom_range(20'hFFFFF)
                                                : $urandom_range(est_time + 400);
                add_req(K_ADMIT, $urandom_range(15),
                        ($urandom_range(15) == 0) ? 0 : $urandom_range(99),
                        $urandom_range(255), $urandom_range(9) == 0 ? 3 : $urandom_range(2),
                        arr, 0, 0);
            end else if (sel < 30) begin
                add_req(K_START, $urandom_range(15), $urandom_range(99), $urandom_range(255),
                        $urandom_range(3), $urandom_range(20'hFFFFF), $urandom_range(255),
                        $urandom_range(1));
                est_time += 20;
            end else if (sel < 85) begin
                dur = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(40);
                add_req(K_INSTR, $urandom_range(15), $urandom_range(99), $urandom_range(255),
                        $urandom_range(3), $urandom_range(20'hFFFFF), dur,
                        $urandom_range(11) == 0);
                est_time += dur;
            end else begin
                add_req(K_TICK, $urandom_range(15), $urandom_range(99), $urandom_range(255),
                        $urandom_range(3), $urandom_range(20'hFFFFF), $urandom_range(255),
                        $urandom_range(1));
                est_time += 1;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase 1: smallest settings, directed corner cases then random
        send_idle_pct = 29;
        configure(1, 1, 0, 1, 1);
        add_req(K_INSTR, 0, 0, 0, 0, 0, 200, 0);          // nothing running
        add_req(K_TICK, 0, 0, 0, 0, 0, 0, 0);             // idle tick, empty table
        add_req(K_START, 0, 0, 0, 0, 0, 0, 0);            // start with empty table
        add_req(K_ADMIT, 15, 99, 255, 3, 0, 0, 0);        // class three stored platinum
        add_req(K_ADMIT, 0, 10, 7, 0, 0, 0, 0);
        add_req(K_ADMIT, 1, 9, 7, 0, 0, 0, 0);            // text order 10 before 9
        add_req(K_ADMIT, 2, 0, 255, 2, 0, 0, 0);          // id zero stays empty
        add_req(K_ADMIT, 3, 64, 0, 1, 20'hFFFFF, 0, 0);   // never ready
        add_req(K_ADMIT, 4, 10, 7, 0, 0, 0, 0);           // full tie with slot 0
        add_req(K_START, 0, 0, 0, 0, 0, 0, 0);
        add_req(K_INSTR, 0, 0, 0, 0, 0, 255, 0);
        add_req(K_INSTR, 0, 0, 0, 0, 0, 255, 0);
        add_req(K_INSTR, 0, 0, 0, 0, 0, 0, 1);            // platinum exits
        add_req(K_INSTR, 0, 0, 0, 0, 0, 0, 0);
        add_req(K_INSTR, 0, 0, 0, 0, 0, 3, 0);
        add_req(K_ADMIT, 4, 50, 200, 0, 0, 0, 0);         // overwrite a waiting entry
        add_req(K_INSTR, 0, 0, 0, 0, 0, 1, 0);
        add_req(K_INSTR, 0, 0, 0, 0, 0, 1, 1);
        add_req(K_INSTR, 0, 0, 0, 0, 0, 1, 1);
        add_req(K_INSTR, 0, 0, 0, 0, 0, 1, 1);
        add_req(K_TICK, 0, 0, 0, 0, 0, 0, 0);
        add_req(K_INSTR, 0, 0, 0, 0, 0, 1, 1);
        add_req(K_TICK, 0, 0, 0, 0, 0, 0, 0);
        est_time = 1200;
        add_random(260);
        drain();

        // phase 2: largest settings
        send_idle_pct = 73;
        configure(1023, 1023, 255, 7, 7);
        add_random(280);
        drain();

        // phase 3: mid settings, no idling
        send_idle_pct = 0;
        configure(50, 90, 10, 3, 5);
        add_random(290);
        drain();

        $display("%0d requests sent, %0d results checked over three register settings",
                 reqs_sent, outs_checked);
        $display("stops: %0d exit, %0d preempt, %0d quantum; %0d promotions",
                 stop_seen[STOP_DONE], stop_seen[STOP_PREEMPT], stop_seen[STOP_QUANTUM],
                 promos_seen);
        if (errors == 0 && expected_outs.size() == 0) begin
            $display("tb_preemptive_priority_task_scheduler_core: done, clean");
        end else begin
            $display("tb_preemptive_priority_task_scheduler_core: done, errors");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
sv/ppts_pkg.sv
sv/ppts_table.sv
sv/preemptive_priority_task_scheduler_core.sv
tb/tb_preemptive_priority_task_scheduler_core.sv
